### hw/rtl/ppq_pkg.sv
package ppq_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned OP_W = 3;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TOS_W = 8;
  localparam int unsigned HND_W = 16;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CNT_W = 7;

  localparam logic [OP_W-1:0] OP_ENQ = 3'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP = 3'd2;
  localparam logic [OP_W-1:0] OP_SEND = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

  localparam logic [KIND_W-1:0] RK_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] RK_FULL = 3'd1;
  localparam logic [KIND_W-1:0] RK_PRESENT = 3'd2;
  localparam logic [KIND_W-1:0] RK_ABSENT = 3'd3;
  localparam logic [KIND_W-1:0] RK_REMOVED = 3'd4;
  localparam logic [KIND_W-1:0] RK_NONE = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [TOS_W-1:0] tos;
    logic [HND_W-1:0] hnd;
  } entry_t;

  // Row command: shift towards the head, append at the tail
  typedef struct packed {
    logic shift;
    logic append;
  } row_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NONE
  } state_t;

endpackage

### hw/rtl/ppq_cell.sv
// One slot of the queue. On shift it takes its right neighbour's entry; the
// tail cell takes the appended entry instead, so a shift and an append can
// land in the same cycle.
module ppq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ppq_pkg::row_ctl_t ctl,
  input  logic              is_tail,
  input  logic              next_valid,
  input  ppq_pkg::entry_t   next_entry,
  input  ppq_pkg::entry_t   new_entry,
  output logic              valid,
  output ppq_pkg::entry_t   entry
);

  logic            valid_r, valid_nxt;
  ppq_pkg::entry_t entry_r, entry_nxt;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctl.append && is_tail) begin
      valid_nxt = 1'b1;
      entry_nxt = new_entry;
    end else if (ctl.shift) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

### hw/rtl/pending_packet_queue_by_destination_core.sv
// Pending packet queue: a row of DEPTH slot cells in arrival order, slot 0
// the oldest. Enqueue and check need no scan (the check compares
// every cell against the destination in parallel). Drop, send and flush
// walk the whole row once through slot 0: each cycle the row shifts by one,
// unless a removed head beat waits on out_tready, and the head entry is
// either emitted as a removed beat or re-appended behind the entries already
// kept; a request that removes nothing ends in a "nothing removed" beat.
// The last flag of a removed beat comes from a parallel look at the
// entries not yet scanned. One request is worked at a time; the output
// register lets the next request in as soon as its beat is taken.
// in_tdata, lowest bit up: opcode[2:0], dest_addr[31:0], src_addr[31:0],
// service_type[7:0], packet_handle[15:0], padded to 96 bits.
module pending_packet_queue_by_destination_core #(
  parameter int unsigned DEPTH = ppq_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // opcode, dest_addr, src_addr, service_type, packet_handle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // result_kind, out_handle, out_dest, out_src,
                                   // out_service_type, forward_flag,
                                   // notify_unreachable, removed_count
  output logic         out_tlast   // last
);

  localparam int unsigned CW = ppq_pkg::CNT_W;

  logic [CW-1:0] max_len_r;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] left_r, left_nxt;    // entries still to pass the head
  logic [CW-1:0] rem_r, rem_nxt;      // removed so far
  logic [CW-1:0] kept_r, kept_nxt;    // entries kept so far, sitting behind the unscanned ones
  logic [ppq_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [ppq_pkg::ADDR_W-1:0] key_r, key_nxt;
  ppq_pkg::state_t st_r, st_nxt;

  logic                 o_vld_r, o_vld_nxt;
  logic [103:0]         o_dat_r, o_dat_nxt;
  logic                 o_last_r, o_last_nxt;

  logic [DEPTH-1:0]     vld;
  ppq_pkg::entry_t      ent [DEPTH];
  ppq_pkg::row_ctl_t    ctl;
  ppq_pkg::entry_t      new_e;
  logic [CW-1:0]        tail_idx;
  logic [DEPTH-1:0]     hit;
  logic [DEPTH-1:0]     dest_eq;
  logic [DEPTH-1:0]     rest_hit;
  logic [ppq_pkg::ADDR_W-1:0] cmp_key;
  logic [CW-1:0]        limit;

  logic [ppq_pkg::OP_W-1:0]   i_op;
  ppq_pkg::entry_t            i_e;
  assign i_op      = in_tdata[2:0];
  assign i_e.dest  = in_tdata[34:3];
  assign i_e.src   = in_tdata[66:35];
  assign i_e.tos   = in_tdata[74:67];
  assign i_e.hnd   = in_tdata[90:75];

  assign limit = (max_len_r < CW'(DEPTH)) ? max_len_r : CW'(DEPTH);

  // One bank of comparators: the incoming destination while idle, the
  // request key while scanning
  assign cmp_key = (st_r == ppq_pkg::ST_IDLE) ? i_e.dest : key_r;

  // The row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    logic            nv;
    ppq_pkg::entry_t ne;
    if (g == DEPTH - 1) begin : g_end
      assign nv = 1'b0;
      assign ne = ent[g];
    end else begin : g_mid
      assign nv = vld[g+1];
      assign ne = ent[g+1];
    end
    ppq_cell u_cell (
      .clk, .rst_n, .ctl,
      .is_tail   (tail_idx == CW'(g)),
      .next_valid(nv),
      .next_entry(ne),
      .new_entry (new_e),
      .valid     (vld[g]),
      .entry     (ent[g])
    );
    assign dest_eq[g]  = (ent[g].dest == cmp_key);
    assign hit[g]      = vld[g] && dest_eq[g];
    // Unscanned entry that the running request will still remove
    assign rest_hit[g] = vld[g] && (CW'(g) < left_r) &&
                         ((op_r == ppq_pkg::OP_FLUSH) || dest_eq[g]);
  end

  logic out_free;
  logic head_match;
  logic more_match;
  assign out_free   = !o_vld_r || out_tready;
  assign head_match = (op_r == ppq_pkg::OP_FLUSH) || dest_eq[0];
  assign more_match = |(rest_hit >> 1);
  assign in_tready  = (st_r == ppq_pkg::ST_IDLE) && out_free;

  always_comb begin
    st_nxt = st_r; held_nxt = held_r; left_nxt = left_r; rem_nxt = rem_r;
    kept_nxt = kept_r; op_nxt = op_r; key_nxt = key_r;
    o_vld_nxt = o_vld_r && !out_tready; o_dat_nxt = o_dat_r; o_last_nxt = o_last_r;
    ctl = '0; new_e = i_e; tail_idx = held_r;
    case (st_r)
      ppq_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          o_dat_nxt = '0; o_last_nxt = 1'b1;
          case (i_op)
            ppq_pkg::OP_ENQ: begin
              o_vld_nxt = 1'b1;
              if (held_r >= limit) begin
                o_dat_nxt[2:0]  = ppq_pkg::RK_FULL;
                o_dat_nxt[18:3] = i_e.hnd;
              end else begin
                o_dat_nxt[2:0] = ppq_pkg::RK_ACCEPTED;
                ctl.append = 1'b1;
                held_nxt = held_r + 1'b1;
              end
            end
            ppq_pkg::OP_CHECK: begin
              o_vld_nxt = 1'b1;
              o_dat_nxt[2:0] = (|hit) ? ppq_pkg::RK_PRESENT : ppq_pkg::RK_ABSENT;
            end
            ppq_pkg::OP_DROP, ppq_pkg::OP_SEND, ppq_pkg::OP_FLUSH: begin
              op_nxt = i_op; key_nxt = i_e.dest;
              left_nxt = held_r; rem_nxt = '0; kept_nxt = '0;
              st_nxt = (held_r == '0) ? ppq_pkg::ST_NONE : ppq_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ppq_pkg::ST_SCAN: begin
        // Shift the head out; emit it, or re-append it behind the kept part
        if (!head_match || out_free) begin
          ctl.shift = 1'b1;
          left_nxt = left_r - CW'(1);
          if (head_match) begin
            rem_nxt = rem_r + CW'(1);
            o_vld_nxt = 1'b1;
            o_dat_nxt = {4'd0, rem_nxt,
                         (op_r == ppq_pkg::OP_DROP) && (rem_r == '0),
                         op_r == ppq_pkg::OP_SEND,
                         ent[0].tos, ent[0].src, ent[0].dest, ent[0].hnd,
                         ppq_pkg::RK_REMOVED};
            o_last_nxt = !more_match;
          end else begin
            ctl.append = 1'b1;
            new_e = ent[0];
            tail_idx = left_r + kept_r - CW'(1);
            kept_nxt = kept_r + CW'(1);
          end
          if (left_r == CW'(1)) begin
            st_nxt = (rem_nxt == '0) ? ppq_pkg::ST_NONE : ppq_pkg::ST_IDLE;
            held_nxt = kept_nxt;
          end
        end
      end
      ppq_pkg::ST_NONE: begin
        if (out_free) begin
          o_vld_nxt = 1'b1; o_dat_nxt = '0; o_dat_nxt[2:0] = ppq_pkg::RK_NONE;
          o_last_nxt = 1'b1; st_nxt = ppq_pkg::ST_IDLE;
        end
      end
      default: st_nxt = ppq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ppq_pkg::ST_IDLE; held_r <= '0; o_vld_r <= 1'b0;
      max_len_r <= CW'(64);
    end else begin
      st_r <= st_nxt; held_r <= held_nxt; o_vld_r <= o_vld_nxt;
      if (cfg_we) max_len_r <= cfg_wdata;
    end
    left_r <= left_nxt; rem_r <= rem_nxt; kept_r <= kept_nxt;
    op_r <= op_nxt; key_r <= key_nxt; o_dat_r <= o_dat_nxt; o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_dat_r;
  assign out_tlast  = o_last_r;

  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("held count beyond depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == ppq_pkg::ST_IDLE))
    else $error("ready while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_tready) |=> (o_vld_r && $stable(o_dat_r) && $stable(o_last_r)))
    else $error("stalled beat changed");

  a_scan_head: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ppq_pkg::ST_SCAN) |-> vld[0])
    else $error("scan with empty head");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= ppq_pkg::RK_NONE))
    else $error("result kind out of range");

endmodule
